>>> rtl/rbd_pkg.sv
// rbd_pkg: command and status codes and the sequencer state type for the
// ring buffer deque. No dependencies.
package rbd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned ITEM_W   = 32;

endpackage

>>> rtl/ring_buffer_deque_top.sv
// ring_buffer_deque_top: double-ended queue in a circular store.
// Depends on rbd_pkg, rbd_store, rbd_ctrl.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   command, item
//   out      out_valid / out_ready status, count, first_item, last_item
//
// Each command is accepted, then the store read of the new end entry after a
// pop comes back. in_ready is high only while no command is in flight.
// A result waits in the output register; the next command is accepted while
// it waits, and its result is held until the output register frees.
// rst is synchronous: pointers, count and cached end items clear at once.
// The store itself is not cleared; only held entries are ever read.
module ring_buffer_deque_top #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   command,
  input  logic [rbd_pkg::ITEM_W-1:0]   item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rbd_pkg::STATUS_W-1:0] status,
  output logic [rbd_pkg::COUNT_W-1:0]  count,
  output logic [rbd_pkg::ITEM_W-1:0]   first_item,
  output logic [rbd_pkg::ITEM_W-1:0]   last_item
);
  import rbd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic                  mem_we, mem_re;
  logic [PTR_W-1:0]      mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  rbd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .count      (count),
    .first_item (first_item),
    .last_item  (last_item),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  rbd_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> rtl/rbd_store.sv
// rbd_store: entry store of the deque, one write port and one read port,
// read data registered. Depends on nothing.
module rbd_store #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PTR_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [PTR_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [PTR_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rbd_ctrl.sv
// rbd_ctrl: pointers, count, cached end items, sequencer and result register.
// Depends on rbd_pkg; drives the port of rbd_store.
module rbd_ctrl #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PTR_W      = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   command,
  input  logic [rbd_pkg::ITEM_W-1:0]   item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rbd_pkg::STATUS_W-1:0] status,
  output logic [rbd_pkg::COUNT_W-1:0]  count,
  output logic [rbd_pkg::ITEM_W-1:0]   first_item,
  output logic [rbd_pkg::ITEM_W-1:0]   last_item,
  output logic                         mem_we,
  output logic [PTR_W-1:0]             mem_waddr,
  output logic [DATA_WIDTH-1:0]        mem_wdata,
  output logic                         mem_re,
  output logic [PTR_W-1:0]             mem_raddr,
  input  logic [DATA_WIDTH-1:0]        mem_rdata
);
  import rbd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  state_t                state;
  logic [PTR_W-1:0]      front, front_next;
  logic [PTR_W-1:0]      back, back_next;
  logic [CNT_W-1:0]      entries, entries_next;
  logic [DATA_WIDTH-1:0] first_q, first_next;
  logic [DATA_WIDTH-1:0] last_q, last_next;
  status_t               res_status, res_status_next;
  logic                  take_first, take_first_next;
  logic                  take_last, take_last_next;
  logic [DATA_WIDTH-1:0] first_fetched, last_fetched;
  logic [DATA_WIDTH-1:0] data;
  logic                  accept, is_full, is_empty, out_free, load_fetch, load_hold;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_full  = (entries == CNT_W'(DEPTH));
  assign is_empty = (entries == '0);
  assign data     = DATA_WIDTH'(item);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    res_status_next = STATUS_OK;
    front_next      = front;
    back_next       = back;
    entries_next    = entries;
    first_next      = first_q;
    last_next       = last_q;
    take_first_next = 1'b0;
    take_last_next  = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = back;
    mem_re          = 1'b0;
    mem_raddr       = ptr_inc(front);
    case (command)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          res_status_next = STATUS_FULL;
        end else begin
          front_next   = ptr_dec(front);
          mem_we       = accept;
          mem_waddr    = ptr_dec(front);
          entries_next = entries + 1'b1;
          first_next   = data;
          if (is_empty) last_next = data;
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          res_status_next = STATUS_FULL;
        end else begin
          back_next    = ptr_inc(back);
          mem_we       = accept;
          mem_waddr    = back;
          entries_next = entries + 1'b1;
          last_next    = data;
          if (is_empty) first_next = data;
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          res_status_next = STATUS_EMPTY;
        end else begin
          front_next   = ptr_inc(front);
          entries_next = entries - 1'b1;
          if (entries == CNT_W'(1)) begin
            first_next = '0;
            last_next  = '0;
          end else begin
            // new front entry comes back from the store next cycle
            mem_re          = accept;
            mem_raddr       = ptr_inc(front);
            take_first_next = 1'b1;
          end
        end
      end
      CMD_POP_BACK: begin
        if (is_empty) begin
          res_status_next = STATUS_EMPTY;
        end else begin
          back_next    = ptr_dec(back);
          entries_next = entries - 1'b1;
          if (entries == CNT_W'(1)) begin
            first_next = '0;
            last_next  = '0;
          end else begin
            // back points one past the last entry, so the new last is two back
            mem_re         = accept;
            mem_raddr      = ptr_dec(ptr_dec(back));
            take_last_next = 1'b1;
          end
        end
      end
      default: begin
        if (is_empty) res_status_next = STATUS_EMPTY;
      end
    endcase
  end

  assign first_fetched = take_first ? mem_rdata : first_q;
  assign last_fetched  = take_last ? mem_rdata : last_q;
  assign load_fetch    = (state == ST_FETCH) && out_free;
  assign load_hold     = (state == ST_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      front      <= '0;
      back       <= '0;
      entries    <= '0;
      first_q    <= '0;
      last_q     <= '0;
      take_first <= 1'b0;
      take_last  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_fetch || load_hold) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            front      <= front_next;
            back       <= back_next;
            entries    <= entries_next;
            first_q    <= first_next;
            last_q     <= last_next;
            res_status <= res_status_next;
            take_first <= take_first_next;
            take_last  <= take_last_next;
            state      <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          first_q    <= first_fetched;
          last_q     <= last_fetched;
          take_first <= 1'b0;
          take_last  <= 1'b0;
          if (out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result beat register, no reset needed
  always_ff @(posedge clk) begin
    if (load_fetch || load_hold) begin
      status <= res_status;
      count  <= COUNT_W'(entries);
    end
    if (load_fetch) begin
      first_item <= ITEM_W'(first_fetched);
      last_item  <= ITEM_W'(last_fetched);
    end else if (load_hold) begin
      first_item <= ITEM_W'(first_q);
      last_item  <= ITEM_W'(last_q);
    end
  end

  assign mem_wdata = data;

endmodule

>>> rtl/rbd_checker.sv
// rbd_checker: port-level checks for ring_buffer_deque_top, bound to it below.
// Depends on rbd_pkg.
module rbd_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [2:0]                   command,
  input logic [rbd_pkg::ITEM_W-1:0]   item,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rbd_pkg::STATUS_W-1:0] status,
  input logic [rbd_pkg::COUNT_W-1:0]  count,
  input logic [rbd_pkg::ITEM_W-1:0]   first_item,
  input logic [rbd_pkg::ITEM_W-1:0]   last_item
);
  import rbd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
      && $stable(first_item) && $stable(last_item))
    else $error("result beat changed while stalled");

  // one command in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while another is in flight");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && count == '0 |-> first_item == '0 && last_item == '0)
    else $error("empty deque reports nonzero end items");

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count <= COUNT_W'(DEPTH)
      && (status != STATUS_FULL || count == COUNT_W'(DEPTH))
      && (status != STATUS_EMPTY || count == '0))
    else $error("status disagrees with count");

endmodule

bind ring_buffer_deque_top rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (.*);

>>> tb/ring_buffer_deque_top_tb.sv
// Self-checking testbench for ring_buffer_deque_top: drives push/pop/peek commands
// and checks every result beat against a shadow deque kept in the bench.
// Depends on rbd_pkg and the ring_buffer_deque_top RTL.
`timescale 1ns / 1ps

module ring_buffer_deque_top_tb;
  import rbd_pkg::*;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned QUIET_TAIL = 250;   // last beats go out without idling
  localparam int unsigned RANDOM_BEATS = 1500;

  // command codes the block treats as peek
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] data;
  } cmd_beat_t;

  typedef struct packed {
    status_t     st;
    logic [6:0]  cnt;
    logic [31:0] first;
    logic [31:0] last;
  } deque_view_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  command;
  logic [31:0] item;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [6:0]  count;
  logic [31:0] first_item;
  logic [31:0] last_item;

  ring_buffer_deque_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .count      (count),
    .first_item (first_item),
    .last_item  (last_item)
  );

  // shadow deque
  logic [31:0] shadow_store [SLOTS];
  logic [5:0]  shadow_front;
  logic [5:0]  shadow_back;   // one past the last held entry
  logic [6:0]  shadow_count;

  cmd_beat_t   pending_cmds [$];
  deque_view_t expected_views [$];

  int  mismatches;
  int  accepted_cmds;
  int  send_gap;
  int  recv_gap;
  bit  in_taken;
  bit  long_hold;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic queue_cmd(input logic [2:0] op, input logic [31:0] data);
    cmd_beat_t b;
    b.op   = op;
    b.data = data;
    pending_cmds.push_back(b);
  endtask

  // Apply one command to the shadow deque and return the view after it.
  function automatic deque_view_t deque_apply(input logic [2:0] op,
                                              input logic [31:0] data);
    deque_view_t v;
    v.st    = STATUS_OK;
    v.first = '0;
    v.last  = '0;
    case (op)
      CMD_PUSH_FRONT: begin
        if (shadow_count == SLOTS) begin
          v.st = STATUS_FULL;
        end else begin
          shadow_front = shadow_front - 6'd1;
          shadow_store[shadow_front] = data;
          shadow_count++;
        end
      end
      CMD_PUSH_BACK: begin
        if (shadow_count == SLOTS) begin
          v.st = STATUS_FULL;
        end else begin
          shadow_store[shadow_back] = data;
          shadow_back = shadow_back + 6'd1;
          shadow_count++;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_count == 0) begin
          v.st = STATUS_EMPTY;
        end else begin
          shadow_front = shadow_front + 6'd1;
          shadow_count--;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          v.st = STATUS_EMPTY;
        end else begin
          shadow_back = shadow_back - 6'd1;
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) v.st = STATUS_EMPTY;
      end
    endcase
    v.cnt = shadow_count;
    if (shadow_count != 0) begin
      v.first = shadow_store[shadow_front];
      v.last  = shadow_store[shadow_back - 6'd1];
    end
    return v;
  endfunction

  // Stimulus: directed corner cases, then runs of pushes, pops and mixed noise.
  initial begin : build_stimulus
    int made;
    int run_len;
    int kind;
    logic [2:0] op;

    queue_cmd(CMD_PEEK, 32'h1234_5678);        // peek on empty
    queue_cmd(CMD_POP_FRONT, 32'hffff_ffff);   // pops on empty
    queue_cmd(CMD_POP_BACK, 32'h0);
    queue_cmd(CMD_SPARE_A, 32'h0);             // spare code on empty
    queue_cmd(CMD_PUSH_FRONT, 32'h0000_0000);  // front pointer wraps below zero
    queue_cmd(CMD_PUSH_BACK, 32'hffff_ffff);
    queue_cmd(CMD_PUSH_FRONT, 32'ha5a5_a5a5);
    queue_cmd(CMD_PEEK, 32'h0);
    queue_cmd(CMD_SPARE_B, 32'hffff_ffff);
    queue_cmd(CMD_SPARE_C, 32'h5a5a_5a5a);
    queue_cmd(CMD_POP_BACK, 32'h0);
    queue_cmd(CMD_POP_FRONT, 32'h0);
    queue_cmd(CMD_POP_BACK, 32'h0);            // back to empty
    queue_cmd(CMD_PEEK, 32'hffff_ffff);
    queue_cmd(CMD_PUSH_BACK, 32'h5a5a_5a5a);
    queue_cmd(CMD_POP_FRONT, 32'h0);
    queue_cmd(CMD_PUSH_BACK, 32'hffff_ffff);
    queue_cmd(CMD_PUSH_FRONT, $urandom);
    queue_cmd(CMD_POP_BACK, 32'h0);
    queue_cmd(CMD_POP_BACK, 32'h0);

    made = 0;
    while (made < RANDOM_BEATS) begin
      kind = $urandom_range(0, 9);
      run_len = (kind < 7) ? $urandom_range(8, 80) : $urandom_range(5, 30);
      for (int i = 0; i < run_len; i++) begin
        if (kind < 7 && $urandom_range(0, 15) == 0) begin
          op = $urandom_range(0, 7);              // noise inside a run
        end else if (kind < 4) begin
          op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else if (kind < 7) begin
          op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end else begin
          op = $urandom_range(0, 7);
        end
        queue_cmd(op, $urandom);
        made++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Input driver
  always @(negedge clk) begin : drive_cmds
    cmd_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
      command  <= '0;
      item     <= '0;
      send_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_cmds.size() > 0) begin
        b = pending_cmds.pop_front();
        in_valid <= 1'b1;
        command  <= b.op;
        item     <= b.data;
        if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
          send_gap <= $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accepted command beats feed the shadow deque.
  always @(posedge clk) begin
    if (rst) begin
      in_taken      <= 1'b0;
      shadow_front  = '0;
      shadow_back   = '0;
      shadow_count  = '0;
      accepted_cmds = 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_views.push_back(deque_apply(command, item));
        accepted_cmds++;
      end
    end
  end

  // Result-side ready: random stall bursts plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      recv_gap  <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hold results off long enough for the block to back up its input.
  initial begin
    while (rst || accepted_cmds < 300) @(posedge clk);
    long_hold = 1'b1;
    repeat (240) @(posedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin : check_results
    deque_view_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        flag_mismatch("unexpected result beat", {30'd0, status}, 32'd0);
      end else begin
        want = expected_views.pop_front();
        if (status !== want.st)        flag_mismatch("status", {30'd0, status}, {30'd0, want.st});
        if (count !== want.cnt)        flag_mismatch("count", {25'd0, count}, {25'd0, want.cnt});
        if (first_item !== want.first) flag_mismatch("first_item", first_item, want.first);
        if (last_item !== want.last)   flag_mismatch("last_item", last_item, want.last);
      end
    end
  end

  initial begin
    @(negedge rst);
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
